// ===== src/afb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ASCII frame builder: character codes, the character slot layout of a frame,
// the job record and the hex digit function. It has no dependencies.
package afb_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_SEP   = 8'h3B;

  localparam int unsigned SLOT_W = 4;

  // Character slots of a frame: '<' CC ';' LL, then a slot that holds ';' for a header or the
  // data byte for a data item, and the trailer ';' SS '>'.
  localparam logic [SLOT_W-1:0] SLOT_OPEN     = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_CODE_HI  = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_CODE_LO  = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_SEP_A    = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_LEN_HI   = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_LEN_LO   = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_SEP_B    = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_SEP_C    = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_SUM_HI   = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_SUM_LO   = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_CLOSE    = 4'd10;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  typedef enum logic {
    JOB_HEADER,
    JOB_DATA
  } job_kind_e;

  typedef struct packed {
    job_kind_e         kind;
    logic              trailer;
    logic [7:0]        frame_code;
    logic [7:0]        data_length;
    logic [7:0]        data_byte;
    logic [7:0]        sum;
    logic [SLOT_W-1:0] slot;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
    logic [7:0] wide;
    wide = {4'h0, nibble};
    return (nibble < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
  endfunction

endpackage

// ===== src/afb_if.sv =====
`timescale 1ns / 1ps
// Ready/valid channel interfaces for the ASCII frame builder: one for input items,
// one for output characters. They have no dependencies.
interface afb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] frame_code;
  logic [7:0] data_length;
  logic [7:0] data_byte;

  modport source (output valid, cmd, frame_code, data_length, data_byte, input ready);
  modport sink   (input valid, cmd, frame_code, data_length, data_byte, output ready);
endinterface

interface afb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       frame_end;

  modport source (output valid, out_char, frame_end, input ready);
  modport sink   (input valid, out_char, frame_end, output ready);
endinterface

// ===== src/ascii_frame_builder_with_checksum_unit.sv =====
`timescale 1ns / 1ps
// Top level of the ASCII frame builder with additive checksum.
// Depends on afb_pkg and on the channel interfaces in afb_if.sv.
//
// The block takes items on in_i and sends the characters of the frame <CC;LL;data;SS> on
// out_o, one character per transfer, with frame_end set on the closing '>'. A start item
// (cmd = 0) sends seven header characters, or eleven when its length is zero. Each data
// item inside a frame sends its byte, and the last byte of a frame adds four trailer
// characters. A data item outside a frame is taken and dropped.
//
// An accepted item is turned into a job record at the accepting edge; its first character
// moves from the job register into the output register once the output register is free.
// The job register walks the slots one per cycle while the output is free, and a new item
// is taken in the cycle that the job hands over its last character. Data bytes flow at one
// per cycle unless out_o stalls; a start item sends 7 or 11 characters, a closing byte 5.
//
// Reset clears the checksum, the byte count, the open frame flag and both valid flags.
// When the receiver holds out_o.ready low the output register keeps its character, the
// job waits, and in_i.ready falls once the job is busy.
module ascii_frame_builder_with_checksum_unit
  import afb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  afb_in_if.sink   in_i,
  afb_out_if.source out_o
);

  logic       in_frame_q, in_frame_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] left_q, left_d;

  logic job_valid_q, job_valid_d;
  job_t job_q, job_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_end_q, out_end_d;

  logic       out_free;
  logic       job_adv;
  logic       job_last;
  logic       in_acc;
  logic [7:0] head_sum;
  logic [7:0] data_sum;
  logic [7:0] left_dec;
  logic [7:0] slot_char;

  assign out_free = !out_valid_q || out_o.ready;
  assign job_adv  = job_valid_q && out_free;
  assign job_last = job_q.trailer ? (job_q.slot == SLOT_CLOSE) : (job_q.slot == SLOT_SEP_B);
  assign in_i.ready = !job_valid_q || (job_adv && job_last);
  assign in_acc   = in_i.valid && in_i.ready;

  assign head_sum = hex_digit(in_i.frame_code[7:4]) + hex_digit(in_i.frame_code[3:0])
                  + hex_digit(in_i.data_length[7:4]) + hex_digit(in_i.data_length[3:0])
                  + CH_SEP + CH_SEP;
  assign data_sum = sum_q + in_i.data_byte;
  assign left_dec = left_q - 8'd1;

  always_comb begin
    in_frame_d  = in_frame_q;
    sum_d       = sum_q;
    left_d      = left_q;
    job_valid_d = job_valid_q;
    job_d       = job_q;
    if (job_adv) begin
      if (job_last) begin
        job_valid_d = 1'b0;
      end else begin
        job_d.slot = job_q.slot + 4'd1;
      end
    end
    if (in_acc) begin
      if (in_i.cmd == CMD_START) begin
        sum_d             = head_sum;
        left_d            = in_i.data_length;
        in_frame_d        = (in_i.data_length != 8'd0);
        job_valid_d       = 1'b1;
        job_d.kind        = JOB_HEADER;
        job_d.trailer     = (in_i.data_length == 8'd0);
        job_d.frame_code  = in_i.frame_code;
        job_d.data_length = in_i.data_length;
        job_d.data_byte   = in_i.data_byte;
        job_d.sum         = head_sum;
        job_d.slot        = SLOT_OPEN;
      end else if (in_frame_q) begin
        sum_d             = data_sum;
        left_d            = left_dec;
        in_frame_d        = (left_dec != 8'd0);
        job_valid_d       = 1'b1;
        job_d.kind        = JOB_DATA;
        job_d.trailer     = (left_dec == 8'd0);
        job_d.frame_code  = in_i.frame_code;
        job_d.data_length = in_i.data_length;
        job_d.data_byte   = in_i.data_byte;
        job_d.sum         = data_sum;
        job_d.slot        = SLOT_SEP_B;
      end
    end
  end

  always_comb begin
    case (job_q.slot)
      SLOT_OPEN:    slot_char = CH_OPEN;
      SLOT_CODE_HI: slot_char = hex_digit(job_q.frame_code[7:4]);
      SLOT_CODE_LO: slot_char = hex_digit(job_q.frame_code[3:0]);
      SLOT_SEP_A:   slot_char = CH_SEP;
      SLOT_LEN_HI:  slot_char = hex_digit(job_q.data_length[7:4]);
      SLOT_LEN_LO:  slot_char = hex_digit(job_q.data_length[3:0]);
      SLOT_SEP_B:   slot_char = (job_q.kind == JOB_DATA) ? job_q.data_byte : CH_SEP;
      SLOT_SEP_C:   slot_char = CH_SEP;
      SLOT_SUM_HI:  slot_char = hex_digit(job_q.sum[7:4]);
      SLOT_SUM_LO:  slot_char = hex_digit(job_q.sum[3:0]);
      SLOT_CLOSE:   slot_char = CH_CLOSE;
      default:      slot_char = CH_CLOSE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_end_d   = out_end_q;
    if (out_free) begin
      out_valid_d = job_valid_q;
      out_char_d  = slot_char;
      out_end_d   = job_valid_q && (job_q.slot == SLOT_CLOSE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      sum_q       <= 8'd0;
      left_q      <= 8'd0;
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      sum_q       <= sum_d;
      left_q      <= left_d;
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_char_q <= out_char_d;
    out_end_q  <= out_end_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_char  = out_char_q;
  assign out_o.frame_end = out_end_q;

  // An open frame always expects at least one more byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_frame_q |-> (left_q != 8'd0))
    else $error("open frame with no bytes left");

  // The job slot never runs past the closing character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_q.slot <= SLOT_CLOSE))
    else $error("job slot out of range");

  // A frame end is only ever flagged on the closing character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_end_q) |-> (out_char_q == CH_CLOSE))
    else $error("frame end on a character other than the closing one");

  // A job that waits on a stalled output keeps its slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !out_free && !in_acc) |=> $stable(job_q.slot))
    else $error("job slot moved while the output was stalled");

endmodule

// ===== tb/ascii_frame_builder_with_checksum_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of ascii_frame_builder_with_checksum_unit: a frame predictor class and
// directed plus random items with random idling on both channels.
// Depends on afb_pkg, the channel interfaces in afb_if.sv and the block itself.
import afb_pkg::*;

typedef struct packed {
  logic [7:0] out_char;
  logic       frame_end;
} frame_char_t;

class frame_predictor;
  frame_char_t expected_q[$];
  logic [7:0]  checksum;
  logic [7:0]  bytes_left;
  bit          in_frame;
  string       hex_digits = "0123456789ABCDEF";
  int unsigned errors;
  int unsigned productive_items;
  int unsigned ignored_items;
  int unsigned frames_started;
  int unsigned frames_closed;
  int unsigned chars_checked;

  function new();
    checksum   = 8'h00;
    bytes_left = 8'h00;
    in_frame   = 1'b0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void push_char(logic [7:0] ch, logic fend);
    frame_char_t c;
    c.out_char  = ch;
    c.frame_end = fend;
    expected_q.push_back(c);
  endfunction

  function void push_summed(logic [7:0] ch);
    checksum = checksum + ch;
    push_char(ch, 1'b0);
  endfunction

  function void close_frame();
    in_frame = 1'b0;
    frames_closed++;
    push_char(CH_SEP, 1'b0);
    push_char(hex_digits[checksum[7:4]], 1'b0);
    push_char(hex_digits[checksum[3:0]], 1'b0);
    push_char(CH_CLOSE, 1'b1);
  endfunction

  function void note_item(logic cmd, logic [7:0] code, logic [7:0] len, logic [7:0] dbyte);
    if (cmd == CMD_START) begin
      productive_items++;
      frames_started++;
      checksum = 8'h00;
      push_char(CH_OPEN, 1'b0);
      push_summed(hex_digits[code[7:4]]);
      push_summed(hex_digits[code[3:0]]);
      push_summed(CH_SEP);
      push_summed(hex_digits[len[7:4]]);
      push_summed(hex_digits[len[3:0]]);
      push_summed(CH_SEP);
      bytes_left = len;
      if (len == 8'h00) begin
        close_frame();
      end else begin
        in_frame = 1'b1;
      end
    end else if (in_frame) begin
      productive_items++;
      push_summed(dbyte);
      bytes_left = bytes_left - 8'h01;
      if (bytes_left == 8'h00) begin
        close_frame();
      end
    end else begin
      ignored_items++;
    end
  endfunction

  function void check_char(logic [7:0] ch, logic fend);
    frame_char_t want;
    chars_checked++;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected character: expected none, actual 8'h%02h end %0b",
               $time, ch, fend);
      return;
    end
    want = expected_q.pop_front();
    if (ch !== want.out_char) begin
      errors++;
      $display("%0t: out_char mismatch: expected 8'h%02h, actual 8'h%02h",
               $time, want.out_char, ch);
    end
    if (fend !== want.frame_end) begin
      errors++;
      $display("%0t: frame_end mismatch: expected %0b, actual %0b",
               $time, want.frame_end, fend);
    end
  endfunction
endclass

module ascii_frame_builder_with_checksum_unit_test;
  localparam int unsigned ITEM_TARGET = 410;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned IDLE_PCT    = 18;

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int unsigned quiet_cycles;
  frame_predictor pred;

  afb_in_if  in_if ();
  afb_out_if out_if ();

  ascii_frame_builder_with_checksum_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic drive_item(logic cmd, logic [7:0] code, logic [7:0] len, logic [7:0] dbyte);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid       <= 1'b0;
      in_if.cmd         <= 1'($urandom_range(1));
      in_if.frame_code  <= 8'($urandom_range(255));
      in_if.data_length <= 8'($urandom_range(255));
      in_if.data_byte   <= 8'($urandom_range(255));
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.frame_code  <= code;
    in_if.data_length <= len;
    in_if.data_byte   <= dbyte;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_start(logic [7:0] code, logic [7:0] len);
    drive_item(CMD_START, code, len, 8'($urandom_range(255)));
  endtask

  task automatic send_data(logic [7:0] dbyte);
    drive_item(CMD_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)), dbyte);
  endtask

  task automatic wait_for_outputs();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pred.pending() != 0) @(negedge clk_i);
  endtask

  task automatic send_frame();
    int unsigned sel;
    int unsigned len;
    int unsigned count;
    sel = $urandom_range(99);
    if (sel < 75) begin
      len = $urandom_range(6);
    end else if (sel < 95) begin
      len = $urandom_range(31, 7);
    end else begin
      len = $urandom_range(255);
    end
    count = (len > 31) ? $urandom_range(5) : len;
    if (len > 0 && $urandom_range(9) == 0) begin
      count = $urandom_range(len - 1);
    end
    send_start(8'($urandom_range(255)), 8'(len));
    repeat (count) send_data(8'($urandom_range(255)));
  endtask

  // Samples both channels at every rising edge and ends the run if nothing moves for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni) begin
        quiet_cycles++;
        if (in_if.valid && in_if.ready) begin
          quiet_cycles = 0;
          pred.note_item(in_if.cmd, in_if.frame_code, in_if.data_length, in_if.data_byte);
        end
        if (out_if.valid && out_if.ready) begin
          quiet_cycles = 0;
          pred.check_char(out_if.out_char, out_if.frame_end);
        end
      end
    end
    $display("%0t: timeout with %0d characters still expected", $time, pred.pending());
    $display("** ascii_frame_builder_with_checksum_unit: FAILED **");
    $finish;
  end

  initial begin
    bit mid_drain_done;
    int unsigned pick;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    steady            = 1'b0;
    mid_drain_done    = 1'b0;
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_START;
    in_if.frame_code  = 8'h00;
    in_if.data_length = 8'h00;
    in_if.data_byte   = 8'h00;
    out_if.ready      = 1'b0;
    pred = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_data(8'h55);
    send_start(8'h00, 8'h00);
    send_start(8'hFF, 8'h00);
    send_start(8'h9A, 8'h01);
    send_data(8'h00);
    send_start(8'h3C, 8'h03);
    send_data(8'hFF);
    send_data(8'h80);
    send_data(8'h01);
    send_start(8'hC3, 8'hFF);
    send_data(8'hAA);
    send_data(8'h55);
    send_start(8'h12, 8'h02);
    send_data(8'h7E);
    send_data(8'hFE);
    send_data(8'h01);
    send_start(8'h0F, 8'h80);
    send_data(8'h00);
    send_start(8'hF0, 8'h00);
    send_start(8'h6B, 8'h02);
    send_data(8'h00);
    send_data(8'h00);
    wait_for_outputs();

    while (pred.productive_items < ITEM_TARGET) begin
      steady = (pred.productive_items >= 120 && pred.productive_items < 200);
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame();
      end else if (pick < 85) begin
        send_data(8'($urandom_range(255)));
      end else begin
        send_start(8'($urandom_range(255)), 8'($urandom_range(255)));
        repeat ($urandom_range(3)) send_data(8'($urandom_range(255)));
      end
      if (!mid_drain_done && pred.productive_items >= 280) begin
        mid_drain_done = 1'b1;
        wait_for_outputs();
      end
    end
    steady = 1'b0;
    wait_for_outputs();
    repeat (8) @(negedge clk_i);

    $display("Run covered %0d frame starts, %0d closed frames and %0d ignored data items.",
             pred.frames_started, pred.frames_closed, pred.ignored_items);
    $display("%0d output characters were compared, with %0d mismatches.",
             pred.chars_checked, pred.errors);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("** ascii_frame_builder_with_checksum_unit: PASSED **");
    end else begin
      $display("** ascii_frame_builder_with_checksum_unit: FAILED **");
    end
    $finish;
  end
endmodule
